### rtl/core/bt_pkg.sv
// Shared types, constants and digit helpers for the balanced ternary converter.
package bt_pkg;

    // Width of each result mask field
    localparam int unsigned OUT_BITS = 21;

    // Sequencer states, one-hot
    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } bt_state_t;

    // Control from the sequencer to the digit datapath
    typedef struct packed
    {
        logic load;
        logic step;
    } bt_ctrl_t;

    // Resolved digit codes (base-3 digit plus incoming carry)
    typedef enum logic [1:0]
    {
        DIG_ZERO  = 2'd0,
        DIG_ONE   = 2'd1,
        DIG_TWO   = 2'd2,
        DIG_THREE = 2'd3
    } bt_digit_t;

    // Remainder after taking in one more bit, MSB first: (2*s + b) mod 3
    function automatic logic [1:0] bt_rem_step(input logic [1:0] s, input logic b);
        logic [1:0] r;
        begin
            unique case ({s, b})
                3'b00_0: r = 2'd0;
                3'b00_1: r = 2'd1;
                3'b01_0: r = 2'd2;
                3'b01_1: r = 2'd0;
                3'b10_0: r = 2'd1;
                3'b10_1: r = 2'd2;
                default: r = 2'd0;
            endcase
            return r;
        end
    endfunction

    // Quotient bit of the same long-division step: (2*s + b) >= 3
    function automatic logic bt_quot_bit(input logic [1:0] s, input logic b);
        begin
            return (s == 2'd2) || ((s == 2'd1) && b);
        end
    endfunction

endpackage

### rtl/core/bt_div3.sv
// Divide-by-three unit: parallel-prefix long division over remainder maps.
module bt_div3
    import bt_pkg::*;
#(
    parameter int unsigned WIDTH = 32
)
(
    input  logic [WIDTH-1:0] dividend,
    output logic [WIDTH-1:0] quot,
    output logic [1:0]       rem
);

    localparam int unsigned LEVELS = $clog2(WIDTH);

    // pmap[k][i][s]: remainder after bits covering i upward, starting in state s
    logic [1:0] pmap [LEVELS+1][WIDTH][4];
    logic [1:0] state_in;

    always_comb
    begin
        for (int i = 0; i < WIDTH; i++)
        begin
            for (int s = 0; s < 4; s++)
            begin
                pmap[0][i][s] = bt_rem_step(2'(s), dividend[i]);
            end
        end
        for (int k = 0; k < LEVELS; k++)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                for (int s = 0; s < 4; s++)
                begin
                    if (i + (1 << k) < WIDTH)
                    begin
                        pmap[k+1][i][s] = pmap[k][i][pmap[k][i + (1 << k)][s]];
                    end
                    else
                    begin
                        pmap[k+1][i][s] = pmap[k][i][s];
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_in = 2'd0;
        for (int i = 0; i < WIDTH; i++)
        begin
            state_in = (i == WIDTH - 1) ? 2'd0 : pmap[LEVELS][(i + 1) % WIDTH][0];
            quot[i]  = bt_quot_bit(state_in, dividend[i]);
        end
        rem = pmap[LEVELS][0][0];
    end

endmodule

### rtl/core/bt_serial.sv
// Digit-serial datapath: one balanced ternary digit resolved and shifted in per step.
module bt_serial
    import bt_pkg::*;
#(
    parameter int unsigned INPUT_BITS = 32,
    parameter int unsigned TRIT_COUNT = 21
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bt_ctrl_t              ctrl,
    input  logic [INPUT_BITS-1:0] value,
    output logic [TRIT_COUNT-1:0] plus_cur,
    output logic [TRIT_COUNT-1:0] minus_cur,
    output logic [TRIT_COUNT-1:0] plus_step,
    output logic [TRIT_COUNT-1:0] minus_step
);

    logic [INPUT_BITS-1:0] rest_reg;
    logic [INPUT_BITS-1:0] rest_next;
    logic                  carry_reg;
    logic                  carry_next;
    logic [TRIT_COUNT-1:0] plus_reg;
    logic [TRIT_COUNT-1:0] minus_reg;
    logic [1:0]            rem;
    bt_digit_t             digit;
    logic                  dig_plus;
    logic                  dig_minus;

    bt_div3 #(
        .WIDTH (INPUT_BITS)
    ) u_div3 (
        .dividend (rest_reg),
        .quot     (rest_next),
        .rem      (rem)
    );

    assign digit = bt_digit_t'(rem + {1'b0, carry_reg});

    always_comb
    begin
        dig_plus   = 1'b0;
        dig_minus  = 1'b0;
        carry_next = 1'b0;
        unique case (digit)
            DIG_ZERO:  carry_next = 1'b0;
            DIG_ONE:   dig_plus   = 1'b1;
            DIG_TWO:
            begin
                dig_minus  = 1'b1;
                carry_next = 1'b1;
            end
            DIG_THREE: carry_next = 1'b1;
            default:   carry_next = 1'b0;
        endcase
    end

    // New digit enters at the top; after a full pass bit i holds digit i
    assign plus_step  = {dig_plus,  plus_reg[TRIT_COUNT-1:1]};
    assign minus_step = {dig_minus, minus_reg[TRIT_COUNT-1:1]};
    assign plus_cur   = plus_reg;
    assign minus_cur  = minus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            carry_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rest_reg <= value;
        end
        else if (ctrl.step)
        begin
            rest_reg  <= rest_next;
            plus_reg  <= plus_step;
            minus_reg <= minus_step;
        end
    end

endmodule

### rtl/core/balanced_ternary_converter_top.sv
// Top level of the binary to balanced ternary converter: sequencer and result register.
//
// Usage:
//   Input channel: value is taken on a beat (in_valid high, in_stall low).
//   Output channel: plus_mask / minus_mask leave on a beat (out_valid high,
//   out_stall low). Bit i of plus_mask marks digit +1 at weight 3^i, bit i
//   of minus_mask marks digit -1; a bit is never set in both.
//   An accepted beat runs through the digit loop, and its masks go to the
//   result register when that register is free.
//   The digit loop resolves one base-3 digit and its carry per cycle
//   through a single divide-by-three unit; the sequencer takes no new
//   input until the current item has left the loop.
//   The input is taken again while a finished result waits in the output
//   register; if the next result is ready before that one leaves, the
//   sequencer holds it and stalls the input until the register frees up.
//   Reset clears the sequencer and the output valid flag; no result is
//   shown until an item has been converted.
module balanced_ternary_converter_top
    import bt_pkg::*;
#(
    parameter int unsigned INPUT_BITS = 32,
    parameter int unsigned TRIT_COUNT = 21
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [INPUT_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_BITS-1:0]   plus_mask,
    output logic [OUT_BITS-1:0]   minus_mask
);

    localparam int unsigned CNT_W = $clog2(TRIT_COUNT);
    localparam int unsigned KEEP  = (TRIT_COUNT < OUT_BITS) ? TRIT_COUNT : OUT_BITS;

    bt_state_t             state_reg;
    bt_state_t             state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_BITS-1:0]   plus_mask_reg;
    logic [OUT_BITS-1:0]   minus_mask_reg;
    logic [OUT_BITS-1:0]   plus_mask_next;
    logic [OUT_BITS-1:0]   minus_mask_next;

    bt_ctrl_t              ctrl;
    logic                  in_beat;
    logic                  out_free;
    logic                  last_digit;
    logic                  load_out;
    logic [TRIT_COUNT-1:0] plus_cur;
    logic [TRIT_COUNT-1:0] minus_cur;
    logic [TRIT_COUNT-1:0] plus_step;
    logic [TRIT_COUNT-1:0] minus_step;
    logic [TRIT_COUNT-1:0] plus_sel;
    logic [TRIT_COUNT-1:0] minus_sel;

    bt_serial #(
        .INPUT_BITS (INPUT_BITS),
        .TRIT_COUNT (TRIT_COUNT)
    ) u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .value      (value),
        .plus_cur   (plus_cur),
        .minus_cur  (minus_cur),
        .plus_step  (plus_step),
        .minus_step (minus_step)
    );

    // Only an idle sequencer takes a new beat
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_beat    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign last_digit = (cnt_reg == CNT_W'(TRIT_COUNT - 1));

    assign ctrl = '{load: in_beat, step: (state_reg == ST_RUN)};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_digit)
                begin
                    // Hand the finished masks straight over when the register is free
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Fresh masks on the last digit, stored masks while holding
    assign plus_sel  = (state_reg == ST_HOLD) ? plus_cur  : plus_step;
    assign minus_sel = (state_reg == ST_HOLD) ? minus_cur : minus_step;

    always_comb
    begin
        plus_mask_next              = '0;
        minus_mask_next             = '0;
        plus_mask_next[KEEP-1:0]    = plus_sel[KEEP-1:0];
        minus_mask_next[KEEP-1:0]   = minus_sel[KEEP-1:0];
    end

    always_comb
    begin
        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            plus_mask_reg  <= plus_mask_next;
            minus_mask_reg <= minus_mask_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign plus_mask  = plus_mask_reg;
    assign minus_mask = minus_mask_reg;

`ifndef SYNTHESIS
    // A digit is either +1 or -1, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((plus_mask & minus_mask) == '0))
    else $error("digit marked in both masks");

    // Hold only while a previous result still occupies the register
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> out_valid_reg)
    else $error("holding with an empty result register");

    // An accepted beat starts the digit loop from the lowest digit
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> ((state_reg == ST_RUN) && (cnt_reg == '0)))
    else $error("digit loop did not start after accept");

    // The digit counter never passes the last digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg <= CNT_W'(TRIT_COUNT - 1)))
    else $error("digit counter overran");

    // A result waiting on a stalled receiver is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !load_out)
    else $error("stalled result overwritten");
`endif

endmodule

### bench/tb_balanced_ternary_converter_top.sv
// Self-checking testbench for the binary to balanced ternary converter top level.
module tb_balanced_ternary_converter_top;
    import bt_pkg::*;

    localparam int unsigned IN_BITS    = 32;
    localparam int unsigned TRITS      = 21;
    localparam int unsigned RAND_BEATS = 1950;
    // Worst serial beat: longest idle gap, a full digit pass and longest stall, plus one long hold-off.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 400;
    // Settle time after the last result: two full digit passes and some margin.
    localparam int unsigned DRAIN_CYCLES = 2 * TRITS + 4;
    localparam int unsigned DIRECTED_ROWS = 24;

    // Idle patterns: full range of waits, no waits at all, short waits only
    localparam int unsigned IDLE_FULL  = 0;
    localparam int unsigned IDLE_NONE  = 1;
    localparam int unsigned IDLE_SHORT = 2;

    typedef struct packed
    {
        logic [OUT_BITS-1:0] plus_bits;
        logic [OUT_BITS-1:0] minus_bits;
    } mask_pair_t;

    // One directed row: the value, and the masks where they are typed in by hand
    typedef struct packed
    {
        logic [IN_BITS-1:0] value;
        logic               typed;
        mask_pair_t         masks;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [IN_BITS-1:0]  value;
    logic                out_valid;
    logic                out_stall;
    logic [OUT_BITS-1:0] plus_mask;
    logic [OUT_BITS-1:0] minus_mask;

    mask_pair_t  pending_masks [$];
    int unsigned fail_count;
    int unsigned beats_sent;
    int unsigned beats_checked;
    int unsigned cycle_count;
    int unsigned send_idle_mode;
    bit          hold_request;

    // Directed stimulus. Typed rows are small values and clean carry chains whose
    // balanced ternary form is plain to see; the rest go through the predictor.
    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{32'd0,          1'b1, '{21'h000000, 21'h000000}},  // zero gives empty masks
        '{32'd1,          1'b1, '{21'h000001, 21'h000000}},
        '{32'd2,          1'b1, '{21'h000002, 21'h000001}},  // 3 - 1
        '{32'd3,          1'b1, '{21'h000002, 21'h000000}},
        '{32'd4,          1'b1, '{21'h000003, 21'h000000}},
        '{32'd5,          1'b1, '{21'h000004, 21'h000003}},  // 9 - 3 - 1
        '{32'd13,         1'b1, '{21'h000007, 21'h000000}},  // 9 + 3 + 1
        '{32'd14,         1'b1, '{21'h000008, 21'h000007}},  // 27 - 9 - 3 - 1
        '{32'd1743392200, 1'b1, '{21'h0FFFFF, 21'h000000}},  // twenty +1 digits
        '{32'd1743392201, 1'b1, '{21'h100000, 21'h0FFFFF}},  // carry runs to the top
        '{32'd3486784401, 1'b1, '{21'h100000, 21'h000000}},  // 3^20
        '{32'hFFFFFFFF,   1'b0, '0},
        '{32'hFFFFFFFE,   1'b0, '0},
        '{32'h80000000,   1'b0, '0},
        '{32'h7FFFFFFF,   1'b0, '0},
        '{32'h55555555,   1'b0, '0},
        '{32'hAAAAAAAA,   1'b0, '0},
        '{32'd6,          1'b0, '0},
        '{32'd7,          1'b0, '0},
        '{32'd8,          1'b0, '0},
        '{32'd40,         1'b0, '0},
        '{32'd41,         1'b0, '0},
        '{32'd1162261467, 1'b0, '0},
        '{32'h12345678,   1'b0, '0}
    };

    balanced_ternary_converter_top
    #(
        .INPUT_BITS (IN_BITS),
        .TRIT_COUNT (TRITS)
    )
    u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .plus_mask  (plus_mask),
        .minus_mask (minus_mask)
    );

    always #6 clk = ~clk;

    // Convert to balanced ternary: base-3 digits least significant first, each
    // folded with the incoming carry. Two becomes -1 with a carry, three becomes
    // 0 with a carry. Digits past TRITS are dropped, bits past the field width too.
    function automatic mask_pair_t to_balanced_ternary(input logic [IN_BITS-1:0] v);
        logic [63:0] rest;
        logic [1:0]  carry;
        logic [1:0]  digit;
        mask_pair_t  masks;
        rest  = 64'(v);
        carry = 2'd0;
        masks = '0;
        for (int unsigned pos = 0; pos < TRITS; pos++)
        begin
            digit = 2'(rest % 3) + carry;
            rest  = rest / 3;
            carry = 2'd0;
            case (bt_digit_t'(digit))
                DIG_ONE:
                begin
                    if (pos < OUT_BITS)
                        masks.plus_bits[pos] = 1'b1;
                end
                DIG_TWO:
                begin
                    if (pos < OUT_BITS)
                        masks.minus_bits[pos] = 1'b1;
                    carry = 2'd1;
                end
                DIG_THREE:
                    carry = 2'd1;
                default:
                    carry = 2'd0;
            endcase
        end
        return masks;
    endfunction

    function automatic int unsigned draw_wait(input int unsigned mode);
        if (mode == IDLE_NONE)
            return 0;
        if (mode == IDLE_SHORT)
            return $urandom_range(0, 2);
        return $urandom_range(0, 13);
    endfunction

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                   input logic [OUT_BITS-1:0] want);
        $display("[%0t] mismatch on result %0d: %s got %06h, want %06h",
                 $time, beats_checked, what, got, want);
        fail_count++;
    endtask

    // Offer one beat after a random idle gap, hold it until accepted, then log the
    // expected masks. Valid is left high so a back-to-back beat needs no toggle.
    task automatic send_value(input logic [IN_BITS-1:0] v, input mask_pair_t want);
        int unsigned gap;
        gap = draw_wait(send_idle_mode);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            value    <= $urandom();
        end
        @(negedge clk);
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        pending_masks = {pending_masks, want};
        beats_sent++;
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus: reset, directed table, then the random part
    initial
    begin
        logic [IN_BITS-1:0] pow3 [0:TRITS-1];
        logic [IN_BITS-1:0] v;
        int unsigned        k;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = '0;
        fail_count     = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        hold_request   = 1'b0;
        send_idle_mode = IDLE_FULL;
        pow3[0] = 32'd1;
        for (int unsigned i = 1; i < TRITS; i++)
            pow3[i] = pow3[i-1] * 3;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: typed masks where given, predictor otherwise
        for (int unsigned r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].typed)
                send_value(directed_rows[r].value, directed_rows[r].masks);
            else
                send_value(directed_rows[r].value,
                           to_balanced_ternary(directed_rows[r].value));
        end

        // Random part: full-width values for a third of the draws, plus small values, values close
        // to powers of three and long carry chains, and values near the top.
        for (int unsigned n = 0; n < RAND_BEATS; n++)
        begin
            if (n % 64 == 0)
                send_idle_mode = $urandom_range(IDLE_FULL, IDLE_SHORT);
            // Starve the output for a long stretch while beats keep coming
            if (n == 300)
                hold_request = 1'b1;
            // Pause the sender until the pipeline has emptied
            if (n == 1000)
                wait_drained();
            k = $urandom_range(0, TRITS - 1);
            case ($urandom_range(0, 5))
                0, 1: v = $urandom();
                2:    v = $urandom_range(0, 200);
                3:    v = pow3[k] + $urandom_range(0, 4) - 2;
                4:    v = (pow3[k] - 1) / 2 + $urandom_range(0, 2);
                default: v = 32'hFFFFFFFF - $urandom_range(0, 1000);
            endcase
            send_value(v, to_balanced_ternary(v));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values (%0d directed, %0d random), %0d results checked,",
                 beats_sent, DIRECTED_ROWS, RAND_BEATS, beats_checked);
        $display("with random gaps on both sides, a long output hold-off and a full drain.");
        if (fail_count == 0)
            $display("PASS balanced_ternary_converter_top");
        else
            $display("FAIL balanced_ternary_converter_top");
        $finish;
    end

    // Result side: random stall before each beat, one long hold-off on request,
    // then compare each accepted beat against the oldest expectation.
    initial
    begin
        int unsigned recv_idle_mode;
        int unsigned stall_cycles;
        int unsigned hold_count;
        bit          hold_done;
        mask_pair_t  want;
        out_stall      = 1'b0;
        hold_done      = 1'b0;
        recv_idle_mode = IDLE_FULL;
        wait (rst_n === 1'b1);
        forever
        begin
            if (beats_checked % 50 == 0)
                recv_idle_mode = $urandom_range(IDLE_FULL, IDLE_SHORT);
            if (hold_request && !hold_done)
            begin
                hold_done  = 1'b1;
                hold_count = 0;
                @(negedge clk);
                out_stall <= 1'b1;
                while (hold_count < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_count++;
                end
            end
            stall_cycles = draw_wait(recv_idle_mode);
            repeat (stall_cycles)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_masks.size() == 0)
            begin
                $display("[%0t] result beat with nothing expected: plus %06h minus %06h",
                         $time, plus_mask, minus_mask);
                fail_count++;
            end
            else
            begin
                want = pending_masks.pop_front();
                if (plus_mask !== want.plus_bits)
                    report_mismatch("plus_mask", plus_mask, want.plus_bits);
                if (minus_mask !== want.minus_bits)
                    report_mismatch("minus_mask", minus_mask, want.minus_bits);
            end
            beats_checked++;
        end
    end

    // Watchdog: end the run if it never finishes
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, pending_masks.size());
        $display("FAIL balanced_ternary_converter_top");
        $finish;
    end

endmodule
